>>> hw/rtl/wtsp_pkg.sv
// shared types and constants for the world-to-screen projection block
`default_nettype none

package wtsp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW0_XY        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW0_ZW        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1_XY        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1_ZW        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3_XY        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3_ZW        = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_ORIGIN  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_EXTENT  = 3'd7;

    typedef logic signed [WORD_W-1:0] word_t;

    // matrix rows 0, 1 and 3 plus the window rectangle
    typedef struct packed {
        word_t       m00;
        word_t       m01;
        word_t       m02;
        word_t       m03;
        word_t       m10;
        word_t       m11;
        word_t       m12;
        word_t       m13;
        word_t       m30;
        word_t       m31;
        word_t       m32;
        word_t       m33;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/wtsp_cfg.sv
// configuration register file: matrix rows and window rectangle
`default_nettype none

module wtsp_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [wtsp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [wtsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output wtsp_pkg::cfg_t                        cfg
);
    import wtsp_pkg::*;

    logic [CFG_DATA_W-1:0] row0_xy_reg, row0_zw_reg, row1_xy_reg, row1_zw_reg;
    logic [CFG_DATA_W-1:0] row3_xy_reg, row3_zw_reg;
    logic [31:0]           origin_reg, extent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_xy_reg <= '0;
            row0_zw_reg <= '0;
            row1_xy_reg <= '0;
            row1_zw_reg <= '0;
            row3_xy_reg <= '0;
            row3_zw_reg <= '0;
            origin_reg  <= '0;
            extent_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ROW0_XY:       row0_xy_reg <= cfg_wdata;
                REG_ROW0_ZW:       row0_zw_reg <= cfg_wdata;
                REG_ROW1_XY:       row1_xy_reg <= cfg_wdata;
                REG_ROW1_ZW:       row1_zw_reg <= cfg_wdata;
                REG_ROW3_XY:       row3_xy_reg <= cfg_wdata;
                REG_ROW3_ZW:       row3_zw_reg <= cfg_wdata;
                REG_WINDOW_ORIGIN: origin_reg  <= cfg_wdata[31:0];
                REG_WINDOW_EXTENT: extent_reg  <= cfg_wdata[31:0];
                default:           ;
            endcase
        end
    end

    assign cfg.m00    = row0_xy_reg[31:0];
    assign cfg.m01    = row0_xy_reg[63:32];
    assign cfg.m02    = row0_zw_reg[31:0];
    assign cfg.m03    = row0_zw_reg[63:32];
    assign cfg.m10    = row1_xy_reg[31:0];
    assign cfg.m11    = row1_xy_reg[63:32];
    assign cfg.m12    = row1_zw_reg[31:0];
    assign cfg.m13    = row1_zw_reg[63:32];
    assign cfg.m30    = row3_xy_reg[31:0];
    assign cfg.m31    = row3_xy_reg[63:32];
    assign cfg.m32    = row3_zw_reg[31:0];
    assign cfg.m33    = row3_zw_reg[63:32];
    assign cfg.left   = origin_reg[15:0];
    assign cfg.top    = origin_reg[31:16];
    assign cfg.width  = extent_reg[15:0];
    assign cfg.height = extent_reg[31:16];

endmodule

`default_nettype wire

>>> hw/rtl/wtsp_clip.sv
// clip-space transform: input register, nine products, row sums, saturation
`default_nettype none

module wtsp_clip #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire wtsp_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    input  wire wtsp_pkg::word_t pos_x,
    input  wire wtsp_pkg::word_t pos_y,
    input  wire wtsp_pkg::word_t pos_z,
    output logic                 out_valid,
    output wtsp_pkg::word_t      clip_x,
    output wtsp_pkg::word_t      clip_y,
    output wtsp_pkg::word_t      clip_w
);
    import wtsp_pkg::*;

    localparam logic signed [66:0] SAT_HI = 67'sh7fffffff;
    localparam logic signed [66:0] SAT_LO = -67'sh80000000;

    logic v_in_reg, v_prod_reg, v_sum_reg, v_clip_reg;

    word_t              pos_reg  [0:2];
    word_t              coef     [0:2][0:2];
    word_t              wcoef    [0:2];
    logic signed [63:0] prod_reg [0:2][0:2];
    logic signed [65:0] sum_reg  [0:2];
    logic signed [66:0] wide     [0:2];
    word_t              clip_next[0:2];
    word_t              clip_reg [0:2];

    assign coef[0][0] = cfg.m00;
    assign coef[0][1] = cfg.m01;
    assign coef[0][2] = cfg.m02;
    assign coef[1][0] = cfg.m10;
    assign coef[1][1] = cfg.m11;
    assign coef[1][2] = cfg.m12;
    assign coef[2][0] = cfg.m30;
    assign coef[2][1] = cfg.m31;
    assign coef[2][2] = cfg.m32;
    assign wcoef[0]   = cfg.m03;
    assign wcoef[1]   = cfg.m13;
    assign wcoef[2]   = cfg.m33;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_clip_reg <= 1'b0;
        end else if (en) begin
            v_in_reg   <= in_valid;
            v_prod_reg <= v_in_reg;
            v_sum_reg  <= v_prod_reg;
            v_clip_reg <= v_sum_reg;
        end
    end

    // floor of the exact sum equals the sum of floors plus the carried fraction
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            wide[r] = 67'(sum_reg[r] >>> FRAC_BITS) + 67'(wcoef[r]);
            if (wide[r] > SAT_HI) begin
                clip_next[r] = SAT_HI[31:0];
            end else if (wide[r] < SAT_LO) begin
                clip_next[r] = SAT_LO[31:0];
            end else begin
                clip_next[r] = wide[r][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= coef[r][c] * pos_reg[c];
                end
                sum_reg[r]  <= 66'(prod_reg[r][0]) + 66'(prod_reg[r][1])
                             + 66'(prod_reg[r][2]);
                clip_reg[r] <= clip_next[r];
            end
        end
    end

    assign out_valid = v_clip_reg;
    assign clip_x    = clip_reg[0];
    assign clip_y    = clip_reg[1];
    assign clip_w    = clip_reg[2];

endmodule

`default_nettype wire

>>> hw/rtl/wtsp_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y lanes
`default_nettype none

module wtsp_div #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire wtsp_pkg::word_t       clip_x,
    input  wire wtsp_pkg::word_t       clip_y,
    input  wire wtsp_pkg::word_t       clip_w,
    output logic                       out_valid,
    output logic                       out_near,
    output logic                       out_neg_x,
    output logic                       out_neg_y,
    output logic [FRAC_BITS+31:0]      quot_x,
    output logic [FRAC_BITS+31:0]      quot_y
);
    import wtsp_pkg::*;

    localparam int NW = FRAC_BITS + 32;
    localparam logic signed [31:0] NEAR_LIMIT = 32'(((1 << FRAC_BITS) + 50) / 100);

    logic          v_reg   [0:NW-1];
    logic          near_reg[0:NW-1];
    logic          negx_reg[0:NW-1];
    logic          negy_reg[0:NW-1];
    logic [31:0]   d_reg   [0:NW-1];
    logic [31:0]   rx_reg  [0:NW-1];
    logic [31:0]   ry_reg  [0:NW-1];
    logic [NW-1:0] nqx_reg [0:NW-1];
    logic [NW-1:0] nqy_reg [0:NW-1];

    logic          v_next   [0:NW-1];
    logic          near_next[0:NW-1];
    logic          negx_next[0:NW-1];
    logic          negy_next[0:NW-1];
    logic [31:0]   d_next   [0:NW-1];
    logic [31:0]   rx_next  [0:NW-1];
    logic [31:0]   ry_next  [0:NW-1];
    logic [NW-1:0] nqx_next [0:NW-1];
    logic [NW-1:0] nqy_next [0:NW-1];

    logic [31:0] abs_x, abs_y;

    assign abs_x = clip_x[31] ? (~clip_x + 32'd1) : clip_x;
    assign abs_y = clip_y[31] ? (~clip_y + 32'd1) : clip_y;

    // numerator and quotient share one shift register per lane
    always_comb begin
        logic [31:0]   rx_s, ry_s, d_s, tx, ty;
        logic [NW-1:0] nqx_s, nqy_s;
        logic          gex, gey;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                v_next[k]    = in_valid;
                near_next[k] = clip_w < NEAR_LIMIT;
                negx_next[k] = clip_x[31];
                negy_next[k] = clip_y[31];
                d_s          = clip_w;
                rx_s         = '0;
                ry_s         = '0;
                nqx_s        = {abs_x, {FRAC_BITS{1'b0}}};
                nqy_s        = {abs_y, {FRAC_BITS{1'b0}}};
            end else begin
                v_next[k]    = v_reg[k-1];
                near_next[k] = near_reg[k-1];
                negx_next[k] = negx_reg[k-1];
                negy_next[k] = negy_reg[k-1];
                d_s          = d_reg[k-1];
                rx_s         = rx_reg[k-1];
                ry_s         = ry_reg[k-1];
                nqx_s        = nqx_reg[k-1];
                nqy_s        = nqy_reg[k-1];
            end
            tx          = {rx_s[30:0], nqx_s[NW-1]};
            ty          = {ry_s[30:0], nqy_s[NW-1]};
            gex         = tx >= d_s;
            gey         = ty >= d_s;
            d_next[k]   = d_s;
            rx_next[k]  = gex ? (tx - d_s) : tx;
            ry_next[k]  = gey ? (ty - d_s) : ty;
            nqx_next[k] = {nqx_s[NW-2:0], gex};
            nqy_next[k] = {nqy_s[NW-2:0], gey};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NW; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < NW; k++) begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NW; k++) begin
                near_reg[k] <= near_next[k];
                negx_reg[k] <= negx_next[k];
                negy_reg[k] <= negy_next[k];
                d_reg[k]    <= d_next[k];
                rx_reg[k]   <= rx_next[k];
                ry_reg[k]   <= ry_next[k];
                nqx_reg[k]  <= nqx_next[k];
                nqy_reg[k]  <= nqy_next[k];
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_near  = near_reg[NW-1];
    assign out_neg_x = negx_reg[NW-1];
    assign out_neg_y = negy_reg[NW-1];
    assign quot_x    = nqx_reg[NW-1];
    assign quot_y    = nqy_reg[NW-1];

endmodule

`default_nettype wire

>>> hw/rtl/wtsp_map.sv
// viewport mapping: signed ndc, split extent products, bounds check, output register
`default_nettype none

module wtsp_map #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire wtsp_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    input  wire logic                  in_near,
    input  wire logic                  neg_x,
    input  wire logic                  neg_y,
    input  wire logic [FRAC_BITS+31:0] quot_x,
    input  wire logic [FRAC_BITS+31:0] quot_y,
    output logic                       out_valid,
    output logic                       visible,
    output wtsp_pkg::word_t            screen_x,
    output wtsp_pkg::word_t            screen_y
);
    import wtsp_pkg::*;

    localparam int NW = FRAC_BITS + 32;
    localparam int QW = NW + 1;
    localparam int LW = QW / 2;
    localparam int HW = QW - LW;
    localparam int SW = QW + 20;
    localparam logic signed [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(32'h7fffffff);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic v1_reg, v2_reg, v3_reg, out_valid_reg, visible_reg;
    logic near1_reg, near2_reg, near3_reg;

    logic signed [QW-1:0]   ndcx_reg, ndcy_reg;
    logic [LW+15:0]         plx_reg, ply_reg;
    logic signed [HW+16:0]  phx_reg, phy_reg;
    logic signed [SW-1:0]   sx3_reg, sy3_reg;
    word_t                  sx_reg, sy_reg;

    logic signed [SW-1:0] left_w, top_w, width_w, height_w;
    logic signed [SW-1:0] prodx, prody, sx_next, sy_next;
    logic signed [SW-1:0] satx, saty;
    logic                 in_win, visible_next;

    assign left_w   = $signed(SW'(cfg.left));
    assign top_w    = $signed(SW'(cfg.top));
    assign width_w  = $signed(SW'(cfg.width));
    assign height_w = $signed(SW'(cfg.height));

    // extent product rebuilt from the high signed and low unsigned parts
    assign prodx   = (SW'(phx_reg) <<< LW) + $signed(SW'(plx_reg));
    assign prody   = (SW'(phy_reg) <<< LW) + $signed(SW'(ply_reg));
    assign sx_next = (left_w <<< FRAC_BITS) + (width_w <<< (FRAC_BITS - 1)) + HALF
                   + (prodx >>> 1);
    assign sy_next = (top_w <<< FRAC_BITS) + (height_w <<< (FRAC_BITS - 1)) + HALF
                   - (prody >>> 1);

    assign in_win = (sx3_reg >= (left_w <<< FRAC_BITS))
                 && (sx3_reg <= ((left_w + width_w) <<< FRAC_BITS))
                 && (sy3_reg >= (top_w <<< FRAC_BITS))
                 && (sy3_reg <= ((top_w + height_w) <<< FRAC_BITS));
    assign visible_next = !near3_reg && in_win;

    assign satx = (sx3_reg > SAT_HI) ? SAT_HI : ((sx3_reg < SAT_LO) ? SAT_LO : sx3_reg);
    assign saty = (sy3_reg > SAT_HI) ? SAT_HI : ((sy3_reg < SAT_LO) ? SAT_LO : sy3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
        end else if (en) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
            visible_reg   <= visible_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            near1_reg <= in_near;
            near2_reg <= near1_reg;
            near3_reg <= near2_reg;
            ndcx_reg  <= neg_x ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
            ndcy_reg  <= neg_y ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
            plx_reg   <= ndcx_reg[LW-1:0] * cfg.width;
            ply_reg   <= ndcy_reg[LW-1:0] * cfg.height;
            phx_reg   <= $signed(ndcx_reg[QW-1:LW]) * $signed({1'b0, cfg.width});
            phy_reg   <= $signed(ndcy_reg[QW-1:LW]) * $signed({1'b0, cfg.height});
            sx3_reg   <= sx_next;
            sy3_reg   <= sy_next;
            sx_reg    <= visible_next ? satx[31:0] : '0;
            sy_reg    <= visible_next ? saty[31:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;

    a_zero_when_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !visible_reg |-> sx_reg == '0 && sy_reg == '0)
        else $error("hidden point carries nonzero coordinates");

    a_visible_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && visible_reg |-> !sx_reg[31] && !sy_reg[31])
        else $error("visible point left of or above the screen origin");

    a_near_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v3_reg && near3_reg |=> out_valid_reg && !visible_reg)
        else $error("point behind the near limit reported visible");

endmodule

`default_nettype wire

>>> hw/rtl/world_to_screen_projection.sv
// top level of the world-to-screen perspective projection pipeline
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    s_pos_x, s_pos_y, s_pos_z
//  m_*          out  m_valid/m_ready    m_visible, m_screen_x, m_screen_y
//  cfg_*        in   cfg_wr_en          cfg_addr, cfg_wdata
//
// one transaction per cycle while no result is held at the output; 4 clip stages,
// one divider stage per quotient bit, 4 mapping stages
// the divider depth, 32+FRAC_BITS stages, sets the latency
// reset clears every valid bit and the visible flag; other payload registers are left as they are
// a result held at the output stalls the whole pipeline through one enable
`default_nettype none

module world_to_screen_projection #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [wtsp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [wtsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire wtsp_pkg::word_t                  s_pos_x,
    input  wire wtsp_pkg::word_t                  s_pos_y,
    input  wire wtsp_pkg::word_t                  s_pos_z,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_visible,
    output wtsp_pkg::word_t                       m_screen_x,
    output wtsp_pkg::word_t                       m_screen_y
);
    import wtsp_pkg::*;

    cfg_t                  cfg;
    logic                  en;
    logic                  clip_valid;
    word_t                 clip_x, clip_y, clip_w;
    logic                  div_valid, div_near, div_neg_x, div_neg_y;
    logic [FRAC_BITS+31:0] quot_x, quot_y;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    wtsp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .pos_z     (s_pos_z),
        .out_valid (clip_valid),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .clip_w    (clip_w)
    );

    wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (clip_valid),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .clip_w    (clip_w),
        .out_valid (div_valid),
        .out_near  (div_near),
        .out_neg_x (div_neg_x),
        .out_neg_y (div_neg_y),
        .quot_x    (quot_x),
        .quot_y    (quot_y)
    );

    wtsp_map #(.FRAC_BITS(FRAC_BITS)) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .in_near   (div_near),
        .neg_x     (div_neg_x),
        .neg_y     (div_neg_y),
        .quot_x    (quot_x),
        .quot_y    (quot_y),
        .out_valid (m_valid),
        .visible   (m_visible),
        .screen_x  (m_screen_x),
        .screen_y  (m_screen_y)
    );

endmodule

`default_nettype wire
